FILE: design/ntdt_pkg.sv
package ntdt_pkg;

    localparam int NODES     = 1024;
    localparam int SLOTS     = 8;
    localparam int TIME_BITS = 16;

    localparam int NODE_W  = 10;
    localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ROW_W   = (NODES > 1) ? $clog2(NODES) : 1;
    localparam int ADDR_W  = ROW_W + SLOT_W;
    localparam int VAL_W   = 32;
    localparam int ENTRY_W = TIME_BITS + 5 * VAL_W;

    localparam logic [2:0] CMD_COST   = 3'd0;
    localparam logic [2:0] CMD_ACCESS = 3'd1;
    localparam logic [2:0] CMD_STORE  = 3'd2;
    localparam logic [2:0] CMD_PURGE  = 3'd3;
    localparam logic [2:0] CMD_CLEAR  = 3'd4;

    localparam logic REG_BASE_COST   = 1'b0;
    localparam logic REG_PURGE_VALUE = 1'b1;

    typedef struct packed {
        logic              row_rd;
        logic              row_eval;
        logic              row_wb;
        logic              clr_step;
        logic              sweep_start;
        logic              sweep_sel;
        logic              out_ld;
    } ntdt_cmd_t;

    typedef struct packed {
        logic last_row;
    } ntdt_stat_t;

endpackage

FILE: design/node_time_dual_table.sv
// Query, access, store and unknown commands: a row valid read, one slot read per cycle,
// then one write/output step before the result (states RD, SCAN, FIN).
// Purge reads, scans and writes back each row in turn (RD, SCAN, PWB); clear steps CLR
// over every row; both then give their result from SOUT. One beat in flight; the next
// is accepted the cycle after the result is taken.
// Reset (synchronous) sets base_cost=1, purge_value=0, then clears every row's valid bits.
module node_time_dual_table (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    // cmd, node, timestep, in_north, in_south, in_east, in_west, in_wait; pad
    input  logic [191:0] s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // out_north, out_south, out_east, out_west, out_wait, found, overflow; pad
    output logic [167:0] m_tdata,
    input  logic         cfg_we,
    input  logic         cfg_addr,
    input  logic [31:0]  cfg_wdata
);
    logic        base_cost_reg;
    logic [31:0] purge_value_reg;
    logic [2:0]  cmd_reg;
    logic [9:0]  node_reg;
    logic [15:0] time_reg;
    logic [159:0] in_reg;
    logic        s_fire;
    ntdt_pkg::ntdt_cmd_t  ctl;
    ntdt_pkg::ntdt_stat_t stat;
    logic [159:0] ov;
    logic found, ovf;

    assign s_fire = s_tvalid && s_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            base_cost_reg   <= 1'b1;
            purge_value_reg <= '0;
        end else if (cfg_we) begin
            if (cfg_addr == ntdt_pkg::REG_BASE_COST) base_cost_reg <= cfg_wdata[0];
            else purge_value_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            cmd_reg  <= s_tdata[2:0];
            node_reg <= s_tdata[12:3];
            time_reg <= s_tdata[28:13];
            for (int k = 0; k < 5; k++) in_reg[(4-k)*32 +: 32] <= s_tdata[29+k*32 +: 32];
        end
    end

    logic [2:0] cur_cmd;
    assign cur_cmd = s_fire ? s_tdata[2:0] : cmd_reg;

    ntdt_ctrl u_ctrl (
        .aclk, .aresetn, .s_fire, .cmd(cur_cmd), .m_tready,
        .s_tready, .m_tvalid, .stat, .ctl
    );

    ntdt_datapath u_dp (
        .aclk, .aresetn, .ctl, .stat,
        .base_cost(base_cost_reg), .purge_value(purge_value_reg),
        .cmd(cmd_reg), .node(node_reg), .timestep(time_reg), .in_vals(in_reg),
        .out_vals_reg(ov), .found_reg(found), .overflow_reg(ovf)
    );

    assign m_tdata = {6'd0, ovf, found, ov[31:0], ov[63:32], ov[95:64], ov[127:96],
                      ov[159:128]};
endmodule

FILE: design/ntdt_datapath.sv
module ntdt_datapath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  ntdt_pkg::ntdt_cmd_t    ctl,
    output ntdt_pkg::ntdt_stat_t   stat,
    input  logic                   base_cost,
    input  logic [31:0]            purge_value,
    input  logic [2:0]             cmd,
    input  logic [9:0]             node,
    input  logic [15:0]            timestep,
    input  logic [5*32-1:0]        in_vals,
    output logic [5*32-1:0]        out_vals_reg,
    output logic                   found_reg,
    output logic                   overflow_reg
);
    localparam int TOTAL = ntdt_pkg::NODES * ntdt_pkg::SLOTS;

    logic [ntdt_pkg::ENTRY_W-1:0] mem [TOTAL];
    logic [ntdt_pkg::SLOTS-1:0]   vmem [ntdt_pkg::NODES];

    logic [ntdt_pkg::ENTRY_W-1:0]   rd_reg;
    logic [ntdt_pkg::SLOTS-1:0]     vrow_reg;
    logic [ntdt_pkg::SLOTS-1:0]     kill_reg;
    logic [ntdt_pkg::SLOT_W-1:0]    scan_reg;
    logic [ntdt_pkg::SLOT_W-1:0]    prev_slot_reg;
    logic                           have_hit_reg;
    logic [ntdt_pkg::SLOT_W-1:0]    hit_slot_reg;
    logic [ntdt_pkg::ENTRY_W-1:0]   hit_data_reg;
    logic [ntdt_pkg::ROW_W-1:0]     sw_row_reg;

    logic [ntdt_pkg::ROW_W-1:0]     row;
    logic [ntdt_pkg::ROW_W-1:0]     row_sel;
    logic [ntdt_pkg::ADDR_W-1:0]    rd_addr;
    logic                           node_ok;
    logic [ntdt_pkg::TIME_BITS-1:0] tkey;
    logic                           cur_valid;
    logic                           cur_match;
    logic                           sweep_match;
    logic                           have_free;
    logic [ntdt_pkg::SLOT_W-1:0]    free_slot;
    logic                           is_rw;
    logic                           is_write;
    logic                           do_insert;
    logic [ntdt_pkg::ENTRY_W-1:0]   new_entry;
    logic [ntdt_pkg::SLOT_W-1:0]    wslot;
    logic                           vm_we;
    logic [ntdt_pkg::ROW_W-1:0]     vm_waddr;
    logic [ntdt_pkg::SLOTS-1:0]     vm_wdata;

    assign row     = node[ntdt_pkg::ROW_W-1:0];
    assign node_ok = {22'd0, node} < ntdt_pkg::NODES;
    assign tkey    = timestep[ntdt_pkg::TIME_BITS-1:0];
    assign row_sel = ctl.sweep_sel ? sw_row_reg : row;

    // row scan: valid bits of the row and slot 0 first, then one slot per cycle
    always_comb begin
        if (ctl.row_rd) begin
            rd_addr = {row_sel, {ntdt_pkg::SLOT_W{1'b0}}};
        end else begin
            rd_addr = {row_sel, scan_reg};
        end
    end

    always_ff @(posedge aclk) begin
        rd_reg <= mem[rd_addr];
        if (ctl.row_rd) vrow_reg <= vmem[row_sel];
    end

    // free slot: first invalid
    always_comb begin
        have_free = 1'b0;
        free_slot = '0;
        for (int s = ntdt_pkg::SLOTS - 1; s >= 0; s--) begin
            if (!vrow_reg[s]) begin
                have_free = 1'b1;
                free_slot = ntdt_pkg::SLOT_W'(s);
            end
        end
    end

    function automatic logic [31:0] cost_of(input logic b, input logic [31:0] v);
        logic signed [33:0] c;
        c = $signed({17'd0, b, 16'd0}) - $signed({{2{v[31]}}, v});
        if (c > 34'sd2147483647) begin
            return 32'h7fff_ffff;
        end else if (c < -34'sd2147483648) begin
            return 32'h8000_0000;
        end
        return c[31:0];
    endfunction

    assign cur_valid = vrow_reg[prev_slot_reg];
    assign cur_match = cur_valid && rd_reg[ntdt_pkg::ENTRY_W-1 -: ntdt_pkg::TIME_BITS] == tkey;
    assign sweep_match = cur_valid && rd_reg[159:128] == purge_value
        && rd_reg[127:96] == purge_value && rd_reg[95:64] == purge_value
        && rd_reg[63:32] == purge_value && rd_reg[31:0] == purge_value;

    assign stat.last_row = sw_row_reg == ntdt_pkg::ROW_W'(ntdt_pkg::NODES - 1);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            scan_reg      <= '0;
            prev_slot_reg <= '0;
            have_hit_reg  <= 1'b0;
            kill_reg      <= '0;
        end else if (ctl.row_rd) begin
            scan_reg      <= ntdt_pkg::SLOT_W'(1);
            prev_slot_reg <= '0;
            have_hit_reg  <= 1'b0;
            kill_reg      <= '0;
        end else if (ctl.row_eval) begin
            scan_reg      <= scan_reg + 1'b1;
            prev_slot_reg <= scan_reg;
            if (!have_hit_reg && cur_match) begin
                have_hit_reg <= 1'b1;
                hit_slot_reg <= prev_slot_reg;
                hit_data_reg <= rd_reg;
            end
            if (sweep_match) kill_reg[prev_slot_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || ctl.sweep_start) begin
            sw_row_reg <= '0;
        end else if (ctl.row_wb || ctl.clr_step) begin
            sw_row_reg <= sw_row_reg + 1'b1;
        end
    end

    assign is_rw     = cmd == ntdt_pkg::CMD_ACCESS || cmd == ntdt_pkg::CMD_STORE;
    assign is_write  = node_ok && (have_hit_reg || have_free) && is_rw;
    assign do_insert = node_ok && !have_hit_reg && have_free && is_rw;

    always_comb begin
        vm_we    = 1'b0;
        vm_waddr = sw_row_reg;
        vm_wdata = '0;
        if (ctl.clr_step) begin
            vm_we = 1'b1;
        end else if (ctl.row_wb) begin
            vm_we    = 1'b1;
            vm_wdata = vrow_reg & ~kill_reg;
        end else if (ctl.out_ld && do_insert) begin
            vm_we              = 1'b1;
            vm_waddr           = row;
            vm_wdata           = vrow_reg;
            vm_wdata[free_slot] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (vm_we) vmem[vm_waddr] <= vm_wdata;
    end

    always_comb begin
        wslot = have_hit_reg ? hit_slot_reg : free_slot;
        if (cmd == ntdt_pkg::CMD_STORE) begin
            new_entry = {tkey, in_vals};
        end else if (have_hit_reg) begin
            new_entry = hit_data_reg;
        end else begin
            new_entry = {tkey, 160'd0};
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_ld && is_write) begin
            mem[{row, wslot}] <= new_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl.out_ld) begin
            out_vals_reg <= '0;
            found_reg    <= 1'b0;
            overflow_reg <= 1'b0;
            case (cmd)
                ntdt_pkg::CMD_COST: begin
                    for (int k = 0; k < 5; k++) begin
                        out_vals_reg[k*32 +: 32] <= cost_of(base_cost,
                            (node_ok && have_hit_reg) ? hit_data_reg[k*32 +: 32] : 32'd0);
                    end
                    found_reg <= node_ok && have_hit_reg;
                end
                ntdt_pkg::CMD_ACCESS, ntdt_pkg::CMD_STORE: begin
                    if (node_ok) begin
                        if (have_hit_reg || have_free) begin
                            out_vals_reg <= new_entry[159:0];
                            found_reg    <= have_hit_reg;
                        end else begin
                            overflow_reg <= 1'b1;
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end
endmodule

FILE: design/ntdt_ctrl.sv
module ntdt_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_fire,
    input  logic [2:0]           cmd,
    input  logic                 m_tready,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  ntdt_pkg::ntdt_stat_t stat,
    output ntdt_pkg::ntdt_cmd_t  ctl
);
    typedef enum logic [2:0] {INIT, IDLE, RD, SCAN, FIN, PWB, CLR, SOUT} state_t;
    state_t state_reg;
    logic [ntdt_pkg::SLOT_W:0] cnt_reg;
    logic sweep;

    assign sweep = cmd == ntdt_pkg::CMD_PURGE || cmd == ntdt_pkg::CMD_CLEAR;
    assign s_tready = state_reg == IDLE && !m_tvalid;

    always_comb begin
        ctl = '0;
        ctl.row_rd      = state_reg == RD;
        ctl.row_eval    = state_reg == SCAN;
        ctl.row_wb      = state_reg == PWB;
        ctl.clr_step    = state_reg == INIT || state_reg == CLR;
        ctl.sweep_start = s_fire && sweep;
        ctl.sweep_sel   = (state_reg == RD || state_reg == SCAN || state_reg == PWB) &&
                          cmd == ntdt_pkg::CMD_PURGE;
        ctl.out_ld      = state_reg == FIN || state_reg == SOUT;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= INIT;
            m_tvalid  <= 1'b0;
            cnt_reg   <= '0;
        end else begin
            if (m_tvalid && m_tready) m_tvalid <= 1'b0;
            case (state_reg)
                INIT: if (stat.last_row) state_reg <= IDLE;
                IDLE: if (s_fire) begin
                    state_reg <= (cmd == ntdt_pkg::CMD_CLEAR) ? CLR : RD;
                end
                RD: begin
                    state_reg <= SCAN;
                    cnt_reg   <= '0;
                end
                SCAN: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == (ntdt_pkg::SLOT_W + 1)'(ntdt_pkg::SLOTS - 1)) begin
                        state_reg <= (cmd == ntdt_pkg::CMD_PURGE) ? PWB : FIN;
                    end
                end
                FIN: begin
                    state_reg <= IDLE;
                    m_tvalid  <= 1'b1;
                end
                PWB: state_reg <= stat.last_row ? SOUT : RD;
                CLR: if (stat.last_row) state_reg <= SOUT;
                SOUT: begin
                    state_reg <= IDLE;
                    m_tvalid  <= 1'b1;
                end
                default: state_reg <= IDLE;
            endcase
        end
    end
endmodule
